/* hw/rtl/pbpm_pkg.sv */
// Shared types, codes and widths of the packet buffer pool manager.
package pbpm_pkg;

	localparam int MODE_W      = 3;
	localparam int IDX_W       = 4;
	localparam int BYTES_W     = 13;
	localparam int REF_W       = 8;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int FAIL_W      = 16;

	localparam int POOL_SIZE_DEF    = 16;
	localparam int BUFFER_BYTES_DEF = 2048;

	localparam logic [REF_W-1:0] REF_MAX = 8'd255;

	// One descriptor word: reference count, data length, head offset.
	localparam int DESC_W = REF_W + 2 * BYTES_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC   = 3'd0,
		MODE_FREE    = 3'd1,
		MODE_REF     = 3'd2,
		MODE_RESERVE = 3'd3,
		MODE_PUSH    = 3'd4,
		MODE_PULL    = 3'd5,
		MODE_PUT     = 3'd6,
		MODE_TRIM    = 3'd7
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_NO_FREE   = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} pbpm_cmd_t;

endpackage

/* hw/rtl/pbpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pbpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/pbpm_ctrl.sv */
// Command sequencer: accept, execute and result hand-off of the pool manager.
module pbpm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output pbpm_pkg::pbpm_cmd_t cmd
);

	import pbpm_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	// The result register must be empty, or emptying now, before a command commits.
	assign cmd.commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_EXEC))
		else $error("accepted transaction did not enter execute");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed command produced no result");

	a_stall_holds_exec: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EXEC) && out_valid_q && !out_ready) |=> (state_q == S_EXEC))
		else $error("command executed over an untaken result");
`endif

endmodule

/* hw/rtl/pbpm_datapath.sv */
// Descriptor store, in-use flags, pool counters and command arithmetic.
module pbpm_datapath #(
	parameter int POOL_SIZE    = pbpm_pkg::POOL_SIZE_DEF,
	parameter int BUFFER_BYTES = pbpm_pkg::BUFFER_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pbpm_pkg::pbpm_cmd_t              cmd,
	input  logic [pbpm_pkg::MODE_W-1:0]      mode,
	input  logic [pbpm_pkg::IDX_W-1:0]       buffer_index,
	input  logic [pbpm_pkg::BYTES_W-1:0]     length,
	input  logic [pbpm_pkg::BYTES_W-1:0]     headroom_bytes,
	output logic [pbpm_pkg::STATUS_W-1:0]    status,
	output logic [pbpm_pkg::IDX_W-1:0]       result_index,
	output logic [pbpm_pkg::BYTES_W-1:0]     data_offset,
	output logic [pbpm_pkg::REF_W-1:0]       ref_count,
	output logic [pbpm_pkg::BYTES_W-1:0]     data_length,
	output logic [pbpm_pkg::COUNT_OUT_W-1:0] free_buffers,
	output logic [pbpm_pkg::COUNT_OUT_W-1:0] peak_in_use,
	output logic [pbpm_pkg::FAIL_W-1:0]      failed_allocs
);

	import pbpm_pkg::*;

	localparam int AW    = $clog2(POOL_SIZE);
	localparam int CNT_W = $clog2(POOL_SIZE + 1);
	localparam int SUM_W = BYTES_W + 1;
	localparam logic [SUM_W-1:0] BB      = SUM_W'(BUFFER_BYTES);
	localparam logic [CNT_W-1:0] POOL_CT = CNT_W'(POOL_SIZE);

	// Captured command.
	mode_t              mode_q;
	logic [IDX_W-1:0]   idx_q;
	logic [BYTES_W-1:0] amt_q;
	logic [BYTES_W-1:0] hr_q;

	// Pool state.
	logic [POOL_SIZE-1:0] in_use_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     wm_q;
	logic [FAIL_W-1:0]    fail_q;
	logic [AW-1:0]        free_idx_q;
	logic                 free_found_q;

	logic [AW-1:0]     free_idx_d;
	logic              free_found_d;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     addr_q;
	logic [DESC_W-1:0] rdata;
	logic [DESC_W-1:0] wdata;
	logic [AW-1:0]     waddr;
	logic              we;

	logic [31:0] idx_port_ext;
	logic [31:0] idx_q_ext;
	logic [31:0] free_idx_ext;
	logic        idx_ok;
	logic        sel_in_use;

	logic [REF_W-1:0]   cur_ref;
	logic [BYTES_W-1:0] cur_len;
	logic [BYTES_W-1:0] cur_head;

	status_t            st;
	logic [IDX_W-1:0]   r_idx;
	logic [BYTES_W-1:0] off;
	logic [REF_W-1:0]   nref;
	logic [BYTES_W-1:0] nlen;
	logic [BYTES_W-1:0] nhead;
	logic               wr;
	logic               set_use;
	logic               clr_use;
	logic               fail_inc;

	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] wm_d;
	logic [FAIL_W-1:0] fail_d;
	logic [CNT_W-1:0] free_ct;
	logic [31:0]      free_ext;
	logic [31:0]      wm_ext;

	assign idx_port_ext = 32'(buffer_index);
	assign idx_q_ext    = 32'(idx_q);
	assign raddr        = idx_port_ext[AW-1:0];
	assign addr_q       = idx_q_ext[AW-1:0];
	assign free_idx_ext = 32'(free_idx_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(mode);
			idx_q  <= buffer_index;
			amt_q  <= length;
			hr_q   <= headroom_bytes;
		end
	end

	// The descriptor word is read while the command is taken and is valid in execute.
	pbpm_ram #(
		.WIDTH(DESC_W),
		.DEPTH(POOL_SIZE)
	) u_desc_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.capture),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Lowest free buffer, refreshed every cycle from the in-use flags.
	always_comb begin
		free_found_d = 1'b0;
		free_idx_d   = '0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found_d = 1'b1;
				free_idx_d   = AW'(i);
			end
		end
	end

	// A buffer that is not in use reads as an all-zero descriptor.
	assign idx_ok     = (idx_q_ext < 32'(POOL_SIZE));
	assign sel_in_use = idx_ok ? in_use_q[addr_q] : 1'b0;
	assign cur_ref    = sel_in_use ? rdata[DESC_W-1 -: REF_W] : '0;
	assign cur_len    = sel_in_use ? rdata[2*BYTES_W-1 -: BYTES_W] : '0;
	assign cur_head   = sel_in_use ? rdata[BYTES_W-1:0] : '0;

	always_comb begin
		st       = ST_OK;
		r_idx    = idx_q;
		off      = cur_head;
		nref     = cur_ref;
		nlen     = cur_len;
		nhead    = cur_head;
		wr       = 1'b0;
		set_use  = 1'b0;
		clr_use  = 1'b0;
		fail_inc = 1'b0;
		waddr    = addr_q;
		if (mode_q == MODE_ALLOC) begin
			r_idx = '0;
			off   = '0;
			nref  = '0;
			nlen  = '0;
			if ((SUM_W'(amt_q) + SUM_W'(hr_q)) > BB) begin
				st       = ST_TOO_LARGE;
				fail_inc = 1'b1;
			end else if (!free_found_q) begin
				st       = ST_NO_FREE;
				fail_inc = 1'b1;
			end else begin
				r_idx   = free_idx_ext[IDX_W-1:0];
				off     = hr_q;
				nref    = REF_W'(1);
				nlen    = '0;
				nhead   = hr_q;
				wr      = 1'b1;
				waddr   = free_idx_q;
				set_use = 1'b1;
			end
		end else if (!sel_in_use) begin
			st = ST_INVALID;
		end else begin
			case (mode_q)
				MODE_FREE: begin
					wr = 1'b1;
					if (cur_ref > REF_W'(1)) begin
						nref = cur_ref - REF_W'(1);
					end else begin
						clr_use = 1'b1;
						nref    = '0;
						nlen    = '0;
						nhead   = '0;
						off     = '0;
					end
				end
				MODE_REF: begin
					wr = 1'b1;
					if (cur_ref != REF_MAX) begin
						nref = cur_ref + REF_W'(1);
					end
				end
				MODE_RESERVE: begin
					if (cur_len != '0) begin
						st = ST_INVALID;
					end else if (SUM_W'(hr_q) > BB) begin
						st = ST_TOO_LARGE;
					end else begin
						wr    = 1'b1;
						nhead = hr_q;
						off   = hr_q;
					end
				end
				MODE_PUSH: begin
					if (amt_q > cur_head) begin
						st = ST_TOO_LARGE;
					end else begin
						wr    = 1'b1;
						nhead = cur_head - amt_q;
						nlen  = cur_len + amt_q;
						off   = cur_head - amt_q;
					end
				end
				MODE_PULL: begin
					if (amt_q > cur_len) begin
						st = ST_TOO_LARGE;
					end else begin
						wr    = 1'b1;
						nhead = cur_head + amt_q;
						nlen  = cur_len - amt_q;
					end
				end
				MODE_PUT: begin
					if ((SUM_W'(cur_len) + SUM_W'(amt_q)) > (BB - SUM_W'(cur_head))) begin
						st = ST_TOO_LARGE;
					end else begin
						wr   = 1'b1;
						off  = cur_head + cur_len;
						nlen = cur_len + amt_q;
					end
				end
				MODE_TRIM: begin
					if (amt_q > cur_len) begin
						st = ST_INVALID;
					end else begin
						wr   = 1'b1;
						nlen = cur_len - amt_q;
					end
				end
				default: begin
					st = ST_OK;
				end
			endcase
		end
	end

	assign we    = cmd.commit && wr;
	assign wdata = {nref, nlen, nhead};

	always_comb begin
		count_d = count_q;
		wm_d    = wm_q;
		fail_d  = fail_q;
		if (set_use) begin
			count_d = count_q + CNT_W'(1);
		end else if (clr_use) begin
			count_d = count_q - CNT_W'(1);
		end
		if (count_d > wm_q) begin
			wm_d = count_d;
		end
		if (fail_inc) begin
			fail_d = fail_q + FAIL_W'(1);
		end
	end

	assign free_ct  = POOL_CT - count_d;
	assign free_ext = 32'(free_ct);
	assign wm_ext   = 32'(wm_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			count_q      <= '0;
			wm_q         <= '0;
			fail_q       <= '0;
			free_idx_q   <= '0;
			free_found_q <= 1'b0;
		end else begin
			free_idx_q   <= free_idx_d;
			free_found_q <= free_found_d;
			if (cmd.commit) begin
				count_q <= count_d;
				wm_q    <= wm_d;
				fail_q  <= fail_d;
				if (set_use) begin
					in_use_q[free_idx_q] <= 1'b1;
				end
				if (clr_use) begin
					in_use_q[addr_q] <= 1'b0;
				end
			end
		end
	end

	// Result register, loaded when the command commits.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status        <= st;
			result_index  <= r_idx;
			data_offset   <= off;
			ref_count     <= nref;
			data_length   <= nlen;
			free_buffers  <= free_ext[COUNT_OUT_W-1:0];
			peak_in_use   <= wm_ext[COUNT_OUT_W-1:0];
			failed_allocs <= fail_d;
		end
	end

`ifndef SYNTHESIS
	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(in_use_q)))
		else $error("buffer count disagrees with in-use flags");

	a_watermark_covers_count: assert property (@(posedge clk) disable iff (!arst_n)
		wm_q >= count_q)
		else $error("high watermark below buffers in use");

	a_alloc_marks_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && set_use) |=> in_use_q[$past(free_idx_q)])
		else $error("allocated buffer not marked in use");
`endif

endmodule

/* hw/rtl/packet_buffer_pool_manager_unit.sv */
// An accepted command moves to execute, and its result is registered when it commits.
// Commands are accepted only when idle, with the descriptor RAM read in the accept
// cycle followed by the read-modify-write in the execute cycle.
// Reset (arst_n low) clears in-use flags, counters and handshake state at once; the
// descriptor RAM is not cleared, since entries of free buffers are masked to zero.
// Top level of the packet buffer pool manager: controller plus datapath.
module packet_buffer_pool_manager_unit #(
	parameter int POOL_SIZE    = pbpm_pkg::POOL_SIZE_DEF,
	parameter int BUFFER_BYTES = pbpm_pkg::BUFFER_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pbpm_pkg::MODE_W-1:0]      mode,
	input  logic [pbpm_pkg::IDX_W-1:0]       buffer_index,
	input  logic [pbpm_pkg::BYTES_W-1:0]     length,
	input  logic [pbpm_pkg::BYTES_W-1:0]     headroom_bytes,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pbpm_pkg::STATUS_W-1:0]    status,
	output logic [pbpm_pkg::IDX_W-1:0]       result_index,
	output logic [pbpm_pkg::BYTES_W-1:0]     data_offset,
	output logic [pbpm_pkg::REF_W-1:0]       ref_count,
	output logic [pbpm_pkg::BYTES_W-1:0]     data_length,
	output logic [pbpm_pkg::COUNT_OUT_W-1:0] free_buffers,
	output logic [pbpm_pkg::COUNT_OUT_W-1:0] peak_in_use,
	output logic [pbpm_pkg::FAIL_W-1:0]      failed_allocs
);

	import pbpm_pkg::*;

	// The controller accepts a command transaction when idle, even while the previous
	// result still waits in the output register. The execute cycle then holds until
	// that result is taken, so no result is ever overwritten.
	pbpm_cmd_t cmd;

	pbpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	// The datapath holds the descriptor RAM, the in-use flags with the lowest-free
	// search, the pool counters and the result register.
	pbpm_datapath #(
		.POOL_SIZE   (POOL_SIZE),
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.buffer_index  (buffer_index),
		.length        (length),
		.headroom_bytes(headroom_bytes),
		.status        (status),
		.result_index  (result_index),
		.data_offset   (data_offset),
		.ref_count     (ref_count),
		.data_length   (data_length),
		.free_buffers  (free_buffers),
		.peak_in_use   (peak_in_use),
		.failed_allocs (failed_allocs)
	);

endmodule

/* verif/tb_packet_buffer_pool_manager_unit.sv */
// Self-checking testbench for the packet buffer pool manager: descriptor predictor and scoreboard.
`timescale 1ns / 100ps

module tb_packet_buffer_pool_manager_unit;

	import pbpm_pkg::*;

	localparam int POOL      = POOL_SIZE_DEF;
	localparam int BUF_BYTES = BUFFER_BYTES_DEF;
	localparam int MAX_BYTES = (1 << BYTES_W) - 1;

	// The slowest legal run has under a thousand commands, each of which may
	// see a long sender gap, its execution and a long stall on the result
	// side. The limit below allows for all of that with a wide margin.
	localparam int CYCLE_LIMIT = 400000;

	// One command as it is driven onto the input ports. The hold flag makes the
	// driver wait until every outstanding result has come back before it
	// launches this command.
	typedef struct {
		mode_t                mode;
		logic [IDX_W-1:0]     idx;
		logic [BYTES_W-1:0]   amount;
		logic [BYTES_W-1:0]   headroom;
		bit                   hold;
	} pool_cmd_t;

	// One result as it appears on the output ports.
	typedef struct packed {
		status_t                status;
		logic [IDX_W-1:0]       idx;
		logic [BYTES_W-1:0]     offset;
		logic [REF_W-1:0]       refs;
		logic [BYTES_W-1:0]     len;
		logic [COUNT_OUT_W-1:0] free;
		logic [COUNT_OUT_W-1:0] peak;
		logic [FAIL_W-1:0]      fails;
	} pool_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [MODE_W-1:0]      mode = '0;
	logic [IDX_W-1:0]       buffer_index = '0;
	logic [BYTES_W-1:0]     length = '0;
	logic [BYTES_W-1:0]     headroom_bytes = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [STATUS_W-1:0]    status;
	logic [IDX_W-1:0]       result_index;
	logic [BYTES_W-1:0]     data_offset;
	logic [REF_W-1:0]       ref_count;
	logic [BYTES_W-1:0]     data_length;
	logic [COUNT_OUT_W-1:0] free_buffers;
	logic [COUNT_OUT_W-1:0] peak_in_use;
	logic [FAIL_W-1:0]      failed_allocs;

	packet_buffer_pool_manager_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.buffer_index   (buffer_index),
		.length         (length),
		.headroom_bytes (headroom_bytes),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.result_index   (result_index),
		.data_offset    (data_offset),
		.ref_count      (ref_count),
		.data_length    (data_length),
		.free_buffers   (free_buffers),
		.peak_in_use    (peak_in_use),
		.failed_allocs  (failed_allocs)
	);

	// Period of 20 ns: ten high, ten low.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Our own copy of the pool: per-buffer descriptors plus the global counters.
	bit   [POOL-1:0]      busy;
	logic [REF_W-1:0]     rc_of [POOL];
	logic [BYTES_W-1:0]   len_of [POOL];
	logic [BYTES_W-1:0]   head_of [POOL];
	int                   n_busy;
	int                   peak_busy;
	logic [FAIL_W-1:0]    n_fail;

	pool_cmd_t            command_backlog [$];
	pool_result_t         due_results [$];
	pool_cmd_t            cur_cmd;
	int                   n_items;
	int                   accepted;
	int                   checked;
	int                   errors;
	int                   cycles;
	int                   status_hits [4];

	task automatic pool_clear();
		int i;
		for (i = 0; i < POOL; i++) begin
			busy[i] = 1'b0;
			rc_of[i] = '0;
			len_of[i] = '0;
			head_of[i] = '0;
		end
		n_busy = 0;
		peak_busy = 0;
		n_fail = '0;
	endtask

	// Applies one command to the pool copy and returns the result it must give.
	// A failed command leaves the descriptors alone; only a failed allocation
	// touches a counter, the failure count.
	function automatic pool_result_t pool_step(input pool_cmd_t c);
		pool_result_t r;
		int i;
		int slot;
		int b;
		r = '0;
		slot = -1;
		b = int'(c.idx);
		if (c.mode == MODE_ALLOC) begin
			if (int'(c.amount) + int'(c.headroom) > BUF_BYTES) begin
				n_fail++;
				r.status = ST_TOO_LARGE;
			end else begin
				// Lowest-numbered free buffer wins.
				for (i = 0; i < POOL; i++)
					if (!busy[i] && slot < 0)
						slot = i;
				if (slot < 0) begin
					n_fail++;
					r.status = ST_NO_FREE;
				end else begin
					busy[slot] = 1'b1;
					rc_of[slot] = REF_W'(1);
					len_of[slot] = '0;
					head_of[slot] = c.headroom;
					n_busy++;
					if (n_busy > peak_busy)
						peak_busy = n_busy;
					r.status = ST_OK;
					r.idx = IDX_W'(slot);
					r.offset = c.headroom;
					r.refs = REF_W'(1);
				end
			end
		end else if (!busy[b]) begin
			// Descriptors of a free buffer are all zero in the pool copy.
			r.status = ST_INVALID;
			r.idx = c.idx;
			r.offset = head_of[b];
			r.refs = rc_of[b];
			r.len = len_of[b];
		end else begin
			r.status = ST_OK;
			r.offset = head_of[b];
			case (c.mode)
				MODE_FREE: begin
					if (rc_of[b] > 1) begin
						rc_of[b]--;
					end else begin
						busy[b] = 1'b0;
						rc_of[b] = '0;
						len_of[b] = '0;
						head_of[b] = '0;
						n_busy--;
					end
					r.offset = head_of[b];
				end
				MODE_REF: begin
					if (rc_of[b] != REF_MAX)
						rc_of[b]++;
				end
				MODE_RESERVE: begin
					if (len_of[b] != 0) begin
						r.status = ST_INVALID;
					end else if (int'(c.headroom) > BUF_BYTES) begin
						r.status = ST_TOO_LARGE;
					end else begin
						head_of[b] = c.headroom;
						r.offset = c.headroom;
					end
				end
				MODE_PUSH: begin
					if (c.amount > head_of[b]) begin
						r.status = ST_TOO_LARGE;
					end else begin
						head_of[b] -= c.amount;
						len_of[b] += c.amount;
						r.offset = head_of[b];
					end
				end
				MODE_PULL: begin
					if (c.amount > len_of[b]) begin
						r.status = ST_TOO_LARGE;
					end else begin
						r.offset = head_of[b];
						head_of[b] += c.amount;
						len_of[b] -= c.amount;
					end
				end
				MODE_PUT: begin
					// Capacity is whatever lies behind the head offset.
					if (int'(len_of[b]) + int'(c.amount) > BUF_BYTES - int'(head_of[b])) begin
						r.status = ST_TOO_LARGE;
					end else begin
						r.offset = head_of[b] + len_of[b];
						len_of[b] += c.amount;
					end
				end
				default: begin
					if (c.amount > len_of[b])
						r.status = ST_INVALID;
					else
						len_of[b] -= c.amount;
				end
			endcase
			r.idx = c.idx;
			r.refs = rc_of[b];
			r.len = len_of[b];
		end
		r.free = COUNT_OUT_W'(POOL - n_busy);
		r.peak = COUNT_OUT_W'(peak_busy);
		r.fails = n_fail;
		return r;
	endfunction

	// Queues a command and runs it through the pool copy at once, so that the
	// generator always knows the state the block will be in when this command
	// arrives. The copy is cleared again before the block leaves reset.
	function automatic pool_result_t queue_command(input mode_t m, input int idx,
			input int amount, input int headroom, input bit hold);
		pool_cmd_t c;
		c.mode = m;
		c.idx = IDX_W'(idx);
		c.amount = BYTES_W'(amount);
		c.headroom = BYTES_W'(headroom);
		c.hold = hold;
		command_backlog.push_back(c);
		return pool_step(c);
	endfunction

	// Byte counts are mostly legal for the given bound, with the bound itself,
	// one past it and full-range values mixed in.
	function automatic int pick_amount(input int bound);
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom_range(bound, 0);
		else if (r < 65)
			return $urandom_range((bound < 32) ? bound : 32, 0);
		else if (r < 75)
			return bound;
		else if (r < 85)
			return (bound < MAX_BYTES) ? bound + 1 : bound;
		else
			return $urandom_range(MAX_BYTES, 0);
	endfunction

	// Most commands go to a buffer that is in use, otherwise they stop at the
	// first check.
	function automatic int pick_busy();
		int i;
		if (n_busy == 0)
			return $urandom_range(POOL - 1, 0);
		i = $urandom_range(POOL - 1, 0);
		while (!busy[i])
			i = $urandom_range(POOL - 1, 0);
		return i;
	endfunction

	// Idle percentage per side. The run is split in thirds by accepted commands:
	// light sender gaps with heavy back-pressure, then the reverse, then full
	// speed on both sides.
	function automatic int idle_pct(input bit sender);
		int third;
		third = (n_items == 0) ? 2 : (accepted * 3) / n_items;
		if (third == 0)
			return sender ? 17 : 52;
		else if (third == 1)
			return sender ? 52 : 17;
		else
			return 0;
	endfunction

	// Driver. A command transaction completes at an edge where valid and ready
	// are both high; that is the moment the command is run through the pool
	// copy and its result joins the list of due results. The next command is
	// launched in the same edge unless the sender idles or the command asks to
	// wait for the pipeline to empty.
	always @(posedge clk) begin : drive
		bit launch;
		if (arst_n) begin
			launch = !in_valid;
			if (in_valid && in_ready) begin
				due_results.push_back(pool_step(cur_cmd));
				accepted++;
				launch = 1'b1;
			end
			if (launch) begin
				if (command_backlog.size() != 0
						&& !(command_backlog[0].hold && due_results.size() != 0)
						&& $urandom_range(99) >= idle_pct(1'b1)) begin
					cur_cmd = command_backlog.pop_front();
					in_valid <= 1'b1;
					mode <= cur_cmd.mode;
					buffer_index <= cur_cmd.idx;
					length <= cur_cmd.amount;
					headroom_bytes <= cur_cmd.headroom;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: result %0d %s mismatch, expected %0d, actual %0d",
				$time, checked, name, want, got);
		end
	endtask

	// Monitor. Each result transaction is held against the oldest due result,
	// field by field. Ready toggles at random according to the current third.
	always @(posedge clk) begin : watch
		pool_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t ns: result with nothing expected, status %0d index %0d",
						$time, status, result_index);
				end else begin
					want = due_results.pop_front();
					check_field("status", 16'(want.status), 16'(status));
					check_field("result_index", 16'(want.idx), 16'(result_index));
					check_field("data_offset", 16'(want.offset), 16'(data_offset));
					check_field("ref_count", 16'(want.refs), 16'(ref_count));
					check_field("data_length", 16'(want.len), 16'(data_length));
					check_field("free_buffers", 16'(want.free), 16'(free_buffers));
					check_field("peak_in_use", 16'(want.peak), 16'(peak_in_use));
					check_field("failed_allocs", want.fails, failed_allocs);
					status_hits[want.status]++;
					checked++;
				end
			end
			out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	// Watchdog on total cycles.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d results still due", $time, due_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		pool_result_t res;
		int k;
		int bias;
		int r;
		int alloc_w;
		int free_w;
		int target;
		int idx;
		int hr;
		mode_t m;
		pool_clear();

		// Directed part: every command, the field extremes and each failure path but the full pool.
		void'(queue_command(MODE_FREE, 0, 0, 0, 0));              // free of an idle buffer
		void'(queue_command(MODE_TRIM, 15, MAX_BYTES, MAX_BYTES, 0));
		void'(queue_command(MODE_ALLOC, 9, 0, 0, 0));             // buffer 0, no headroom
		void'(queue_command(MODE_ALLOC, 0, BUF_BYTES, 0, 0));     // exactly the buffer size
		void'(queue_command(MODE_ALLOC, 0, 1, BUF_BYTES, 0));     // one byte too many
		void'(queue_command(MODE_ALLOC, 15, MAX_BYTES, MAX_BYTES, 0));
		void'(queue_command(MODE_ALLOC, 0, 0, BUF_BYTES, 0));     // buffer 2, all headroom
		void'(queue_command(MODE_PUSH, 2, BUF_BYTES + 1, 0, 0));  // beyond the headroom
		void'(queue_command(MODE_PUSH, 2, BUF_BYTES, 0, 0));      // buffer 2 now full
		void'(queue_command(MODE_PUT, 2, 1, 0, 0));               // beyond the capacity
		void'(queue_command(MODE_PULL, 2, BUF_BYTES + 1, 0, 0));  // beyond the length
		void'(queue_command(MODE_PULL, 2, 48, 0, 0));
		void'(queue_command(MODE_TRIM, 2, BUF_BYTES - 47, 0, 0)); // trim beyond the length
		void'(queue_command(MODE_TRIM, 2, BUF_BYTES - 48, 0, 0)); // back to empty
		void'(queue_command(MODE_RESERVE, 2, 0, BUF_BYTES + 1, 0));
		void'(queue_command(MODE_RESERVE, 2, 0, BUF_BYTES, 0));
		void'(queue_command(MODE_PUT, 0, 100, 0, 0));
		void'(queue_command(MODE_RESERVE, 0, 0, 10, 0));          // buffer holds data
		void'(queue_command(MODE_REF, 0, 0, 0, 0));
		void'(queue_command(MODE_FREE, 0, 0, 0, 0));              // one reference left
		void'(queue_command(MODE_FREE, 0, 0, 0, 0));              // released
		void'(queue_command(MODE_FREE, 0, 0, 0, 0));              // already released
		void'(queue_command(MODE_PUSH, 3, 0, 0, 0));              // never allocated
		void'(queue_command(MODE_PUT, 1, MAX_BYTES, 0, 0));
		void'(queue_command(MODE_ALLOC, 0, 0, MAX_BYTES, 0));

		// Random part. Epochs of sixty loop passes lean toward filling the pool,
		// draining it, or a balanced mix, so the pool-full case and the empty
		// pool both come up. A tenth of the commands are pure noise.
		bias = 0;
		for (k = 0; k < 220; k++) begin
			if (k % 60 == 0)
				bias = $urandom_range(2, 0);
			if (k == 110) begin
				// Drive one buffer to the reference ceiling and past it.
				res = queue_command(MODE_ALLOC, $urandom_range(POOL - 1, 0), 0, 64, 1'b1);
				target = (res.status == ST_OK) ? int'(res.idx) : pick_busy();
				repeat (256)
					void'(queue_command(MODE_REF, target, $urandom_range(MAX_BYTES, 0),
						$urandom_range(MAX_BYTES, 0), 1'b0));
				void'(queue_command(MODE_FREE, target, 0, 0, 1'b0));
				void'(queue_command(MODE_REF, target, 0, 0, 1'b0));
			end
			if ($urandom_range(99) < 10) begin
				void'(queue_command(mode_t'($urandom_range(7, 0)), $urandom_range(POOL - 1, 0),
					$urandom_range(MAX_BYTES, 0), $urandom_range(MAX_BYTES, 0), k % 100 == 0));
			end else begin
				alloc_w = (bias == 1) ? 50 : (bias == 2) ? 5 : 20;
				free_w = (bias == 1) ? 5 : (bias == 2) ? 45 : 15;
				r = $urandom_range(99);
				if (r < alloc_w)
					m = MODE_ALLOC;
				else if (r < alloc_w + free_w)
					m = MODE_FREE;
				else
					m = mode_t'($urandom_range(MODE_TRIM, MODE_REF));
				idx = pick_busy();
				case (m)
					MODE_ALLOC: begin
						hr = ($urandom_range(1) == 0) ? $urandom_range(128, 0)
							: $urandom_range(BUF_BYTES, 0);
						void'(queue_command(m, $urandom_range(POOL - 1, 0),
							pick_amount(BUF_BYTES - hr), hr, k % 100 == 0));
					end
					MODE_RESERVE:
						void'(queue_command(m, idx, $urandom_range(MAX_BYTES, 0),
							pick_amount(BUF_BYTES), k % 100 == 0));
					MODE_PUSH:
						void'(queue_command(m, idx, pick_amount(int'(head_of[idx])),
							$urandom_range(MAX_BYTES, 0), k % 100 == 0));
					MODE_PULL, MODE_TRIM:
						void'(queue_command(m, idx, pick_amount(int'(len_of[idx])),
							$urandom_range(MAX_BYTES, 0), k % 100 == 0));
					MODE_PUT:
						void'(queue_command(m, idx,
							pick_amount(BUF_BYTES - int'(head_of[idx]) - int'(len_of[idx])),
							$urandom_range(MAX_BYTES, 0), k % 100 == 0));
					default:
						void'(queue_command(m, idx, $urandom_range(MAX_BYTES, 0),
							$urandom_range(MAX_BYTES, 0), k % 100 == 0));
				endcase
			end
		end
		n_items = command_backlog.size();

		// The generator has walked the pool copy forward; bring it back to the
		// reset state before the block starts.
		pool_clear();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(accepted == n_items && due_results.size() == 0))
			@(posedge clk);
		// The wait that follows catches any stray result after the last expected one.
		repeat (8) @(posedge clk);

		$display("Ran %0d commands and checked %0d results; peak pool use %0d of %0d.",
			accepted, checked, peak_busy, POOL);
		$display("Statuses seen: ok %0d, invalid %0d, too large %0d, no free buffer %0d.",
			status_hits[ST_OK], status_hits[ST_INVALID], status_hits[ST_TOO_LARGE],
			status_hits[ST_NO_FREE]);
		if (errors == 0 && due_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/pbpm_pkg.sv
hw/rtl/pbpm_ram.sv
hw/rtl/pbpm_ctrl.sv
hw/rtl/pbpm_datapath.sv
hw/rtl/packet_buffer_pool_manager_unit.sv
verif/tb_packet_buffer_pool_manager_unit.sv
